[src/olst_pkg.sv]
// ----------------------------------------------------------------------------
// olst_pkg: shared definitions for the ordered list store
// Field widths, operation and status codes, and the command and status
// bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package olst_pkg;

  localparam int OP_W    = 3;
  localparam int POS_W   = 6;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 3;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam op_t OP_PUSH   = 3'd0;
  localparam op_t OP_POP    = 3'd1;
  localparam op_t OP_GET    = 3'd2;
  localparam op_t OP_REMOVE = 3'd3;
  localparam op_t OP_INSERT = 3'd4;
  localparam op_t OP_FIND   = 3'd5;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_EMPTY     = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_BAD_INDEX = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd;
    logic take;
    logic walk;
    logic place;
    logic finish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic err;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

[src/olst_ctrl.sv]
// ----------------------------------------------------------------------------
// olst_ctrl: sequencing controller for the ordered list store
// Steps one transaction at a time through decode, memory read, element walk
// and result hand-over, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module olst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output olst_pkg::cmd_t cmd,
  input  olst_pkg::sts_t sts
);
  import olst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_TAKE,
    S_WALK,
    S_PLACE,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.err) begin
          state_nxt = S_FINISH;
        end else begin
          unique case (sts.op)
            OP_POP, OP_GET, OP_REMOVE: state_nxt = S_READ;
            OP_INSERT, OP_FIND:        state_nxt = S_WALK;
            default:                   state_nxt = S_FINISH;
          endcase
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        cmd.take  = 1'b1;
        state_nxt = (sts.op == OP_REMOVE) ? S_WALK : S_FINISH;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = (sts.op == OP_INSERT) ? S_PLACE : S_FINISH;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

[src/olst_dp.sv]
// ----------------------------------------------------------------------------
// olst_dp: datapath of the ordered list store
// Holds the element memory, the element count, the walk cursor and the
// result registers, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
module olst_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  olst_pkg::cmd_t                        cmd,
  output olst_pkg::sts_t                        sts,
  input  logic [olst_pkg::OP_W-1:0]             in_operation,
  input  logic [olst_pkg::POS_W-1:0]            in_position,
  input  logic signed [olst_pkg::WORD_W-1:0]    in_word,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [olst_pkg::WORD_W-1:0]    out_read_word,
  output logic [olst_pkg::POS_W-1:0]            out_found_at,
  output logic [olst_pkg::COUNT_W-1:0]          out_element_count,
  output logic [olst_pkg::STAT_W-1:0]           out_status
);
  import olst_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic signed [WORD_W-1:0] mem [CAPACITY];

  op_t                      op_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [WORD_W-1:0] word_r;
  logic [CW-1:0]            cnt_r;
  logic [AW-1:0]            cur_r;
  logic [AW-1:0]            prev_r;
  logic [CW-1:0]            rem_r;
  logic                     pend_r;
  logic signed [WORD_W-1:0] rdata_r;
  logic signed [WORD_W-1:0] res_word_r;
  logic [POS_W-1:0]         res_found_r;
  status_t                  res_status_r;
  logic                     out_valid_r;
  logic signed [WORD_W-1:0] out_word_r;
  logic [POS_W-1:0]         out_found_r;
  logic [COUNT_W-1:0]       out_count_r;
  status_t                  out_status_r;

  logic [XW-1:0]            pos_x;
  logic [XW-1:0]            cnt_x;
  logic                     is_full;
  logic                     is_empty;
  logic                     err;
  status_t                  err_code;
  logic [AW-1:0]            exec_cur;
  logic [CW-1:0]            exec_rem;
  logic                     hit;
  logic                     issue;
  logic                     rd_en;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [WORD_W-1:0] wr_data;

  assign pos_x    = XW'(pos_r);
  assign cnt_x    = XW'(cnt_r);
  assign is_full  = (cnt_r == CAP_C);
  assign is_empty = (cnt_r == '0);

  always_comb begin
    err      = 1'b0;
    err_code = ST_OK;
    exec_cur = '0;
    exec_rem = '0;
    unique case (op_r)
      OP_PUSH: begin
        err      = is_full;
        err_code = ST_FULL;
      end
      OP_POP: begin
        err      = is_empty;
        err_code = ST_EMPTY;
        exec_cur = AW'(cnt_r - CW'(1));
      end
      OP_GET, OP_REMOVE: begin
        err      = (pos_x >= cnt_x);
        err_code = ST_BAD_INDEX;
        exec_cur = AW'(pos_r);
        exec_rem = cnt_r - CW'(1) - CW'(pos_r);
      end
      OP_INSERT: begin
        if (is_full) begin
          err      = 1'b1;
          err_code = ST_FULL;
        end else if (pos_x > cnt_x) begin
          err      = 1'b1;
          err_code = ST_BAD_INDEX;
        end
        exec_cur = AW'(cnt_r - CW'(1));
        exec_rem = cnt_r - CW'(pos_r);
      end
      OP_FIND: begin
        exec_rem = cnt_r;
      end
      default: begin
        err = 1'b0;
      end
    endcase
  end

  assign hit   = pend_r && (op_r == OP_FIND) && (rdata_r == word_r);
  assign issue = cmd.walk && (rem_r != '0);
  assign rd_en = cmd.rd || issue;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = word_r;
    priority if (cmd.exec && (op_r == OP_PUSH) && !err) begin
      wr_en   = 1'b1;
      wr_addr = AW'(cnt_r);
    end else if (cmd.walk && pend_r && (op_r == OP_REMOVE)) begin
      wr_en   = 1'b1;
      wr_addr = prev_r - AW'(1);
      wr_data = rdata_r;
    end else if (cmd.walk && pend_r && (op_r == OP_INSERT)) begin
      wr_en   = 1'b1;
      wr_addr = prev_r + AW'(1);
      wr_data = rdata_r;
    end else if (cmd.place) begin
      wr_en   = 1'b1;
      wr_addr = AW'(pos_r);
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec && !err) begin
        unique case (op_r)
          OP_PUSH, OP_INSERT: cnt_r <= cnt_r + CW'(1);
          OP_POP, OP_REMOVE:  cnt_r <= cnt_r - CW'(1);
          default:            cnt_r <= cnt_r;
        endcase
      end
      if (cmd.exec) begin
        pend_r <= 1'b0;
      end else if (cmd.walk) begin
        pend_r <= issue;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      pos_r  <= in_position;
      word_r <= in_word;
    end
    if (cmd.exec) begin
      cur_r <= exec_cur;
      rem_r <= exec_rem;
    end else if (cmd.rd) begin
      cur_r <= cur_r + AW'(1);
    end else if (issue) begin
      prev_r <= cur_r;
      rem_r  <= rem_r - CW'(1);
      cur_r  <= (op_r == OP_INSERT) ? (cur_r - AW'(1)) : (cur_r + AW'(1));
    end
    if (cmd.exec) begin
      res_word_r   <= '0;
      res_found_r  <= '0;
      res_status_r <= err ? err_code : ((op_r == OP_FIND) ? ST_NOT_FOUND : ST_OK);
    end else if (cmd.take) begin
      res_word_r <= rdata_r;
    end else if (cmd.walk && hit) begin
      res_found_r  <= POS_W'(prev_r);
      res_status_r <= ST_OK;
    end
    if (cmd.finish) begin
      out_word_r   <= res_word_r;
      out_found_r  <= res_found_r;
      out_count_r  <= COUNT_W'(cnt_r);
      out_status_r <= res_status_r;
    end
  end

  assign sts.op        = op_r;
  assign sts.err       = err;
  assign sts.walk_done = hit || ((rem_r == '0) && !pend_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_read_word     = out_word_r;
  assign out_found_at      = out_found_r;
  assign out_element_count = out_count_r;
  assign out_status        = out_status_r;

endmodule

[src/ordered_list_store.sv]
// ----------------------------------------------------------------------------
// ordered_list_store: fixed-capacity ordered list of signed 32-bit words
// Push, pop, get, remove-at, insert-at and find on a list held in one
// single-port-read, single-port-write memory, one transaction at a time.
// ----------------------------------------------------------------------------
// Usage: a request transaction on the in_ channel carries an operation, a
// position and a word; each request yields exactly one result transaction on
// the out_ channel with the read word, the found position, the element count
// after the request and a status code.
// Push and every rejected request go from decode straight to the result;
// pop and get read one word, remove then shifts the later elements down,
// insert shifts the elements from the position up and find scans from the
// first element until a match or the end. Each walk moves one element per
// cycle through the memory's single read and single write port. A new
// request is accepted in the cycle after the previous result has been
// loaded into the output register, so one result may wait there while the
// next request is taken. When the receiver stalls, the result holds and the
// block waits before loading the next one. After reset the list is empty;
// stored words are not cleared and are only ever read once written.
// ----------------------------------------------------------------------------
module ordered_list_store #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [5:0]         in_position,
  input  logic signed [31:0] in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_read_word,
  output logic [5:0]         out_found_at,
  output logic [6:0]         out_element_count,
  output logic [2:0]         out_status
);
  import olst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  olst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  olst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_position       (in_position),
    .in_word           (in_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_word     (out_read_word),
    .out_found_at      (out_found_at),
    .out_element_count (out_element_count),
    .out_status        (out_status)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another transaction was in progress");

  a_error_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_read_word == '0))
    else $error("failed request returned a non-zero word");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_element_count == '0))
    else $error("empty status reported with a non-zero count");

  a_not_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_FOUND) |-> (out_found_at == '0))
    else $error("not-found status reported with a non-zero position");

endmodule
